// ===== design/miller_rabin_prime_test_defines.svh =====
// assertion macros shared by the design files
`ifndef MILLER_RABIN_PRIME_TEST_DEFINES_SVH
`define MILLER_RABIN_PRIME_TEST_DEFINES_SVH

// implication checked on every edge outside reset
`define MRP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define MRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/mrp_pkg.sv =====
`default_nettype none
package mrp_pkg;
  // modular unit commands
  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_MOD = 2'd1
  } op_e;

  typedef struct packed {
    logic start;
    op_e  op;
  } mod_cmd_t;

  localparam int unsigned NumBases = 3;
  localparam logic [6:0] Base0 = 7'd2;
  localparam logic [6:0] Base1 = 7'd7;
  localparam logic [6:0] Base2 = 7'd61;
endpackage
`default_nettype wire

// ===== design/mrp_modunit.sv =====
`default_nettype none
// shared modular unit: a*b mod m by shift-and-add (msb first), or b mod m
// by restoring shift-subtract; one bit per cycle
module mrp_modunit #(
  parameter int unsigned WIDTH = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mrp_pkg::mod_cmd_t cmd_i,
  input  wire logic [WIDTH-1:0]  a_i,
  input  wire logic [WIDTH-1:0]  b_i,
  input  wire logic [WIDTH-1:0]  m_i,
  output logic                   busy_o,
  output logic                   done_o,
  output logic [WIDTH-1:0]       res_o
);
  `include "miller_rabin_prime_test_defines.svh"

  localparam int unsigned CW = $clog2(WIDTH);

  logic             busy_q, busy_d, done_q;
  logic             is_mul_q;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [WIDTH-1:0] a_q, b_q, m_q, r_q, r_d;
  logic [WIDTH-1:0] b_d;

  // modular addition (x + y) mod m, used for the doubling and the optional addend
  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
                                               input logic [WIDTH-1:0] y,
                                               input logic [WIDTH-1:0] m);
    logic [WIDTH-1:0] room;
    room = m - y;
    add_mod = (x >= room) ? (x - room) : (x + y);
  endfunction

  logic [WIDTH:0]   rem2;
  logic [WIDTH-1:0] dbl;

  // datapath step
  always_comb begin
    dbl  = add_mod(r_q, r_q, m_q);
    rem2 = {r_q, b_q[WIDTH-1]};
    b_d  = {b_q[WIDTH-2:0], 1'b0};
    if (is_mul_q) begin
      r_d = b_q[WIDTH-1] ? add_mod(dbl, a_q, m_q) : dbl;
    end else begin
      r_d = (rem2 >= {1'b0, m_q}) ? WIDTH'(rem2 - {1'b0, m_q}) : rem2[WIDTH-1:0];
    end
    cnt_d  = cnt_q - 1'b1;
    busy_d = busy_q && (cnt_q != '0);
  end

  // control and data registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (cmd_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(WIDTH - 1);
      end else if (busy_q) begin
        busy_q <= busy_d;
        cnt_q  <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start && !busy_q) begin
      is_mul_q <= (cmd_i.op == mrp_pkg::OP_MUL);
      a_q      <= a_i;
      b_q      <= b_i;
      m_q      <= m_i;
      r_q      <= '0;
    end else if (busy_q) begin
      r_q <= r_d;
      b_q <= b_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign res_o  = r_q;

  `MRP_ASSERT_NEXT(a_done_after_busy, clk_i, rst_ni, done_q, !busy_q)
  `MRP_ASSERT_IMP(a_res_below_m, clk_i, rst_ni, done_q, r_q < m_q)
  `MRP_ASSERT_IMP(a_no_start_busy, clk_i, rst_ni, busy_q, !done_q)
endmodule
`default_nettype wire

// ===== design/miller_rabin_prime_test.sv =====
`default_nettype none
// Miller-Rabin primality test with bases 2, 7 and 61.
// Input channel: number_i with number_valid_i; accepted when valid is high
// and number_stall_o is low. Only the low WIDTH bits are used.
// Output channel: is_prime_o with is_prime_valid_o; taken when valid is high
// and is_prime_stall_i is low. One result beat per input beat.
// One item at a time: number_stall_o stays high from acceptance until the
// result has been taken. Trivial numbers (below 2 or even) go straight to
// the output state. Otherwise each base runs a remainder pass, then for each
// exponent d = n-1, (n-1)/2, ... a square-and-multiply over the bits of d;
// every modular product runs in one shared bit-serial unit.
// While the receiver stalls the result is held and no new beat is accepted.
// Reset clears the sequencer; the block then waits for an input beat.
module miller_rabin_prime_test #(
  parameter int unsigned WIDTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [63:0] number_i,
  input  wire logic        number_valid_i,
  output logic             number_stall_o,
  output logic             is_prime_o,
  output logic             is_prime_valid_o,
  input  wire logic        is_prime_stall_i
);
  `include "miller_rabin_prime_test_defines.svh"

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_BASE  = 4'd1;
  localparam logic [3:0] S_REM   = 4'd2;
  localparam logic [3:0] S_POWI  = 4'd3;
  localparam logic [3:0] S_POWB  = 4'd4;
  localparam logic [3:0] S_MULA  = 4'd5;
  localparam logic [3:0] S_SQR   = 4'd6;
  localparam logic [3:0] S_CHECK = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;
  localparam logic [3:0] S_WAIT  = 4'd9;

  localparam int unsigned EW = $clog2(WIDTH + 1);

  logic [3:0]       st_q;
  logic [1:0]       bi_q;
  logic [WIDTH-1:0] n_q, d_q, e_q, b_q, acc_q, base_w, nm1;
  logic [EW-1:0]    sh_q;
  logic             res_q, ovalid_q;
  logic             mul_acc_q;
  mrp_pkg::mod_cmd_t cmd;
  logic [WIDTH-1:0] ua, ub;
  logic             u_busy, u_done;
  logic [WIDTH-1:0] u_res;

  // base table
  always_comb begin
    unique case (bi_q)
      2'd0:    base_w = WIDTH'(mrp_pkg::Base0);
      2'd1:    base_w = WIDTH'(mrp_pkg::Base1);
      default: base_w = WIDTH'(mrp_pkg::Base2);
    endcase
  end
  assign nm1 = n_q - 1'b1;

  // unit command
  always_comb begin
    cmd.start = 1'b0;
    cmd.op    = mrp_pkg::OP_MUL;
    ua        = acc_q;
    ub        = b_q;
    unique case (st_q)
      S_BASE: begin
        cmd.start = 1'b0;
      end
      S_POWI: begin
        cmd.start = 1'b1;
        cmd.op    = mrp_pkg::OP_MOD;
        ua        = '0;
        ub        = base_w;
      end
      S_MULA: begin
        cmd.start = 1'b1;
      end
      S_SQR: begin
        cmd.start = 1'b1;
        ua        = b_q;
      end
      S_REM: begin
        cmd.start = 1'b1;
        cmd.op    = mrp_pkg::OP_MOD;
        ua        = '0;
        ub        = n_q;
      end
      default: cmd.start = 1'b0;
    endcase
  end

  mrp_modunit #(.WIDTH(WIDTH)) u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .a_i    (ua),
    .b_i    (ub),
    .m_i    ((st_q == S_REM) ? base_w : n_q),
    .busy_o (u_busy),
    .done_o (u_done),
    .res_o  (u_res)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      bi_q      <= '0;
      res_q     <= 1'b0;
      ovalid_q  <= 1'b0;
      mul_acc_q <= 1'b0;
      sh_q      <= '0;
      n_q       <= '0;
      d_q       <= '0;
      e_q       <= '0;
      b_q       <= '0;
      acc_q     <= '0;
    end else begin
      unique case (st_q)
        S_IDLE: begin
          if (number_valid_i) begin
            n_q  <= number_i[WIDTH-1:0];
            bi_q <= '0;
            if (number_i[WIDTH-1:0] < WIDTH'(2) || !number_i[0]) begin
              res_q <= (number_i[WIDTH-1:0] == WIDTH'(2));
              st_q  <= S_OUT;
            end else begin
              st_q <= S_BASE;
            end
          end
        end
        S_BASE: begin
          if (n_q == base_w) begin
            res_q <= 1'b1;
            st_q  <= S_OUT;
          end else begin
            st_q <= S_REM;
          end
        end
        S_REM: begin
          // n mod base, unit starts this cycle
          st_q <= S_WAIT;
          mul_acc_q <= 1'b0;
          sh_q <= '0;
        end
        S_POWI: begin
          st_q <= S_POWB;
        end
        S_POWB: begin
          if (u_done) begin
            b_q <= u_res;
            if (e_q == '0) begin
              st_q <= S_CHECK;
            end else if (e_q[0]) begin
              st_q <= S_MULA;
            end else begin
              st_q <= S_SQR;
            end
          end
        end
        S_MULA: begin
          mul_acc_q <= 1'b1;
          st_q      <= S_WAIT;
        end
        S_SQR: begin
          mul_acc_q <= 1'b0;
          st_q      <= S_WAIT;
        end
        S_WAIT: begin
          if (u_done) begin
            if (sh_q == '0 && !mul_acc_q && e_q == '0 && acc_q == '0) begin
              // remainder pass finished
              if (u_res == '0) begin
                res_q <= 1'b0;
                st_q  <= S_OUT;
              end else begin
                d_q   <= nm1;
                e_q   <= nm1;
                acc_q <= WIDTH'(1);
                sh_q  <= EW'(1);
                st_q  <= S_POWI;
              end
            end else if (mul_acc_q) begin
              acc_q <= u_res;
              st_q  <= S_SQR;
            end else begin
              b_q <= u_res;
              e_q <= e_q >> 1;
              if ((e_q >> 1) == '0) begin
                st_q <= S_CHECK;
              end else if (e_q[1]) begin
                st_q <= S_MULA;
              end else begin
                st_q <= S_SQR;
              end
            end
          end
        end
        S_CHECK: begin
          if (d_q[0] || acc_q == nm1) begin
            if (d_q[0] && acc_q != WIDTH'(1) && acc_q != nm1) begin
              res_q <= 1'b0;
              st_q  <= S_OUT;
            end else if (bi_q == 2'(mrp_pkg::NumBases - 1)) begin
              res_q <= 1'b1;
              st_q  <= S_OUT;
            end else begin
              bi_q  <= bi_q + 1'b1;
              acc_q <= '0;
              e_q   <= '0;
              sh_q  <= '0;
              st_q  <= S_BASE;
            end
          end else begin
            d_q   <= d_q >> 1;
            e_q   <= d_q >> 1;
            acc_q <= WIDTH'(1);
            st_q  <= S_POWI;
          end
        end
        S_OUT: begin
          if (ovalid_q && !is_prime_stall_i) begin
            ovalid_q <= 1'b0;
            acc_q    <= '0;
            e_q      <= '0;
            sh_q     <= '0;
            st_q     <= S_IDLE;
          end else begin
            ovalid_q <= 1'b1;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign number_stall_o   = (st_q != S_IDLE);
  assign is_prime_o       = res_q;
  assign is_prime_valid_o = ovalid_q;

  `MRP_ASSERT_IMP(a_valid_only_out, clk_i, rst_ni, ovalid_q, st_q == S_OUT)
  `MRP_ASSERT_IMP(a_unit_idle_at_rest, clk_i, rst_ni, st_q == S_IDLE, !u_busy)
  `MRP_ASSERT_IMP(a_base_in_range, clk_i, rst_ni, st_q != S_IDLE, bi_q != 2'd3)
endmodule
`default_nettype wire
